/* hdl/lbb_pkg.sv */
// Package for the lamp button brightness controller.
// Types, register indexes, level table and reset constants; no dependencies.
`timescale 1ns / 1ps
package lbb_pkg;

    localparam int NUM_STAGES_DEF = 7;
    localparam int STAGE_W        = 3;
    localparam int CNT_W          = 16;
    localparam int DUTY_W         = 12;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 16;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SHORT_MIN = 3'd0,
        CFG_SHORT_MAX = 3'd1,
        CFG_LONG_AT   = 3'd2,
        CFG_OFF_AT    = 3'd3,
        CFG_DIM       = 3'd4,
        CFG_OFF_HOLD  = 3'd5,
        CFG_LOCKOUT   = 3'd6
    } t_cfg_idx;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_SHORT = 2'd1,
        EV_LONG  = 2'd2,
        EV_OFF   = 2'd3
    } t_event;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_MEASURE = 3'd1,
        PH_RELEASE = 3'd2,
        PH_LOCKOUT = 3'd3,
        PH_DIM     = 3'd4,
        PH_OFFHOLD = 3'd5,
        PH_SLEEP   = 3'd6
    } t_phase;

    typedef struct packed {
        logic [CNT_W-1:0] short_min;
        logic [CNT_W-1:0] short_max;
        logic [CNT_W-1:0] long_at;
        logic [CNT_W-1:0] off_at;
        logic [CNT_W-1:0] dim;
        logic [CNT_W-1:0] off_hold;
        logic [CNT_W-1:0] lockout;
    } t_cfg;

    typedef struct packed {
        logic [DUTY_W-1:0] duty_first;
        logic [DUTY_W-1:0] duty_second;
        t_event            press_event;
        logic              sleeping;
    } t_result;

    localparam t_cfg CFG_RESET = '{
        short_min: 16'd2,
        short_max: 16'd1000,
        long_at:   16'd1500,
        off_at:    16'd2500,
        dim:       16'd250,
        off_hold:  16'd2500,
        lockout:   16'd50
    };

    // Stages past the end of the table use the last entry.
    function automatic logic [DUTY_W-1:0] stage_level(input logic [STAGE_W-1:0] stage);
        logic [DUTY_W-1:0] lvl;
        case (stage)
            3'd0:    lvl = 12'd1;
            3'd1:    lvl = 12'd8;
            3'd2:    lvl = 12'd50;
            3'd3:    lvl = 12'd200;
            3'd4:    lvl = 12'd700;
            3'd5:    lvl = 12'd1200;
            default: lvl = 12'd1800;
        endcase
        return lvl;
    endfunction

endpackage

/* hdl/lbb_if.sv */
// Valid/ready stream interfaces for the tick input and the result output.
// Depends on lbb_pkg for field widths.
`timescale 1ns / 1ps
interface lbb_in_if;
    logic valid;
    logic ready;
    logic button_level;

    modport source (output valid, output button_level, input ready);
    modport sink   (input valid, input button_level, output ready);
endinterface

interface lbb_out_if;
    logic                          valid;
    logic                          ready;
    logic [lbb_pkg::DUTY_W-1:0]    duty_first;
    logic [lbb_pkg::DUTY_W-1:0]    duty_second;
    logic [1:0]                    press_event;
    logic                          sleeping;

    modport source (output valid, output duty_first, output duty_second,
                    output press_event, output sleeping, input ready);
    modport sink   (input valid, input duty_first, input duty_second,
                    input press_event, input sleeping, output ready);
endinterface

/* hdl/lbb_cfg.sv */
// Configuration register file: seven 16-bit timing registers, write only.
// Depends on lbb_pkg.
`timescale 1ns / 1ps
module lbb_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_wr_en,
    input  logic [lbb_pkg::CFG_IDX_W-1:0]    i_idx,
    input  logic [lbb_pkg::CFG_DATA_W-1:0]   i_data,
    output lbb_pkg::t_cfg                    o_cfg
);

    lbb_pkg::t_cfg r_cfg;
    lbb_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr_en) begin
            case (i_idx)
                lbb_pkg::CFG_SHORT_MIN: n_cfg.short_min = i_data;
                lbb_pkg::CFG_SHORT_MAX: n_cfg.short_max = i_data;
                lbb_pkg::CFG_LONG_AT:   n_cfg.long_at   = i_data;
                lbb_pkg::CFG_OFF_AT:    n_cfg.off_at    = i_data;
                lbb_pkg::CFG_DIM:       n_cfg.dim       = i_data;
                lbb_pkg::CFG_OFF_HOLD:  n_cfg.off_hold  = i_data;
                lbb_pkg::CFG_LOCKOUT:   n_cfg.lockout   = i_data;
                default:                n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= lbb_pkg::CFG_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* hdl/lbb_core.sv */
// Press timing state machine and duty registers; one tick per step.
// Depends on lbb_pkg.
`timescale 1ns / 1ps
module lbb_core #(
    parameter int NUM_STAGES = lbb_pkg::NUM_STAGES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic              i_level,
    input  lbb_pkg::t_cfg     i_cfg,
    output lbb_pkg::t_result  o_result
);

    localparam int SUM_W = lbb_pkg::STAGE_W + 1;
    localparam logic [SUM_W-1:0] STAGES_LIM = SUM_W'(NUM_STAGES);

    lbb_pkg::t_phase                  r_phase, n_phase;
    logic [lbb_pkg::CNT_W-1:0]        r_cnt, n_cnt;
    logic [lbb_pkg::STAGE_W-1:0]      r_stage, n_stage;
    logic                             r_chan, n_chan;
    logic                             r_prev, n_prev;
    logic                             r_pend, n_pend;
    logic [lbb_pkg::DUTY_W-1:0]       r_duty1, n_duty1;
    logic [lbb_pkg::DUTY_W-1:0]       r_duty2, n_duty2;
    lbb_pkg::t_event                  ev;

    logic                             rising;
    logic [lbb_pkg::CNT_W-1:0]        cnt_inc;
    logic [SUM_W-1:0]                 stage_sum;
    logic [lbb_pkg::STAGE_W-1:0]      stage_adv;
    logic [lbb_pkg::DUTY_W-1:0]       lvl_cur;
    logic [lbb_pkg::DUTY_W-1:0]       lvl_adv;
    logic [lbb_pkg::DUTY_W-1:0]       lvl_dim;

    assign rising    = i_level && !r_prev;
    assign cnt_inc   = (r_cnt == lbb_pkg::CNT_MAX) ? r_cnt : r_cnt + 1'b1;
    assign stage_sum = {1'b0, r_stage} + 1'b1;
    assign stage_adv = (stage_sum >= STAGES_LIM) ? '0 : stage_sum[lbb_pkg::STAGE_W-1:0];
    assign lvl_cur   = lbb_pkg::stage_level(r_stage);
    assign lvl_adv   = lbb_pkg::stage_level(stage_adv);
    assign lvl_dim   = lvl_cur >> 2;

    always_comb begin
        n_phase = r_phase;
        n_cnt   = r_cnt;
        n_stage = r_stage;
        n_chan  = r_chan;
        n_prev  = i_level;
        n_pend  = r_pend;
        n_duty1 = r_duty1;
        n_duty2 = r_duty2;
        ev      = lbb_pkg::EV_NONE;

        case (r_phase)
            lbb_pkg::PH_IDLE: begin
                if (rising || r_pend) begin
                    n_pend  = 1'b0;
                    n_cnt   = '0;
                    n_phase = lbb_pkg::PH_MEASURE;
                end
            end
            lbb_pkg::PH_MEASURE: begin
                if (rising) n_pend = 1'b1;
                if (r_cnt == i_cfg.off_at) begin
                    ev      = lbb_pkg::EV_OFF;
                    n_duty1 = r_chan ? '0 : lvl_dim;
                    n_duty2 = r_chan ? lvl_dim : '0;
                    n_cnt   = '0;
                    n_phase = lbb_pkg::PH_DIM;
                end else if (!i_level) begin
                    if (r_cnt > i_cfg.short_min && r_cnt < i_cfg.short_max) begin
                        ev      = lbb_pkg::EV_SHORT;
                        n_stage = stage_adv;
                        n_duty1 = r_chan ? '0 : lvl_adv;
                        n_duty2 = r_chan ? lvl_adv : '0;
                    end
                    n_cnt   = '0;
                    n_phase = (i_cfg.lockout == '0) ? lbb_pkg::PH_IDLE : lbb_pkg::PH_LOCKOUT;
                end else begin
                    if (r_cnt == i_cfg.long_at) begin
                        ev      = lbb_pkg::EV_LONG;
                        n_chan  = !r_chan;
                        n_duty1 = r_chan ? lvl_cur : '0;
                        n_duty2 = r_chan ? '0 : lvl_cur;
                    end
                    n_cnt = cnt_inc;
                    if (cnt_inc == i_cfg.off_at) begin
                        ev      = lbb_pkg::EV_OFF;
                        n_duty1 = n_chan ? '0 : lvl_dim;
                        n_duty2 = n_chan ? lvl_dim : '0;
                        n_cnt   = '0;
                        n_phase = lbb_pkg::PH_DIM;
                    end
                end
            end
            lbb_pkg::PH_RELEASE: begin
                if (rising) n_pend = 1'b1;
                if (!i_level) begin
                    n_cnt   = '0;
                    n_phase = (i_cfg.lockout == '0) ? lbb_pkg::PH_IDLE : lbb_pkg::PH_LOCKOUT;
                end
            end
            lbb_pkg::PH_LOCKOUT: begin
                if (rising) n_pend = 1'b1;
                n_cnt = cnt_inc;
                if (cnt_inc >= i_cfg.lockout) n_phase = lbb_pkg::PH_IDLE;
            end
            lbb_pkg::PH_DIM: begin
                if (rising) n_pend = 1'b1;
                n_cnt = cnt_inc;
                if (cnt_inc >= i_cfg.dim) begin
                    n_duty1 = '0;
                    n_duty2 = '0;
                    n_stage = '0;
                    n_chan  = !r_chan;
                    n_cnt   = '0;
                    n_phase = lbb_pkg::PH_OFFHOLD;
                end
            end
            lbb_pkg::PH_OFFHOLD: begin
                if (rising) n_pend = 1'b1;
                n_cnt = cnt_inc;
                if (cnt_inc >= i_cfg.off_hold) begin
                    n_cnt   = '0;
                    n_phase = lbb_pkg::PH_SLEEP;
                end
            end
            default: begin
                if (rising) begin
                    n_pend  = 1'b1;
                    n_phase = lbb_pkg::PH_RELEASE;
                end else begin
                    n_phase = lbb_pkg::PH_SLEEP;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= lbb_pkg::PH_IDLE;
            r_cnt   <= '0;
            r_stage <= '0;
            r_chan  <= 1'b0;
            r_prev  <= 1'b0;
            r_pend  <= 1'b0;
            r_duty1 <= '0;
            r_duty2 <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_stage <= n_stage;
            r_chan  <= n_chan;
            r_prev  <= n_prev;
            r_pend  <= n_pend;
            r_duty1 <= n_duty1;
            r_duty2 <= n_duty2;
        end
    end

    // result reflects the state after this tick
    assign o_result.duty_first  = n_duty1;
    assign o_result.duty_second = n_duty2;
    assign o_result.press_event = ev;
    assign o_result.sleeping    = (n_phase == lbb_pkg::PH_SLEEP);

endmodule

/* hdl/lamp_button_brightness_controller.sv */
// Top level of the lamp button brightness controller: input register,
// press state machine, result register. Depends on lbb_pkg, lbb_if, lbb_cfg, lbb_core.
//
//   channel   dir  transfer carries
//   i_in      in   button_level (one millisecond tick)
//   o_out     out  duty_first, duty_second, press_event, sleeping
//   i_cfg_*   in   register index and 16-bit value, write only
//
// One tick per clock sustained while the output is ready; a tick is held in the input
// register, then its state update and its result are registered together.
// The state loop is a single register pass, so ticks follow back to back.
// Synchronous active-low reset restores the register reset values and idle state.
// A stalled output holds its result; the input register still takes one more tick if it is empty.
`timescale 1ns / 1ps
module lamp_button_brightness_controller #(
    parameter int NUM_STAGES = lbb_pkg::NUM_STAGES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [lbb_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [lbb_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    lbb_in_if.sink                          i_in,
    lbb_out_if.source                       o_out
);

    lbb_pkg::t_cfg     cfg;
    lbb_pkg::t_result  core_res;

    logic              r_in_vld;
    logic              r_in_level;
    logic              r_out_vld;
    lbb_pkg::t_result  r_out;
    logic              adv;

    assign adv        = r_in_vld && (!r_out_vld || o_out.ready);
    assign i_in.ready = !r_in_vld || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_in_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_level <= i_in.button_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= core_res;
        end
    end

    lbb_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr_en (i_cfg_wr_en),
        .i_idx   (i_cfg_idx),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    lbb_core #(
        .NUM_STAGES (NUM_STAGES)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (adv),
        .i_level  (r_in_level),
        .i_cfg    (cfg),
        .o_result (core_res)
    );

    assign o_out.valid       = r_out_vld;
    assign o_out.duty_first  = r_out.duty_first;
    assign o_out.duty_second = r_out.duty_second;
    assign o_out.press_event = r_out.press_event;
    assign o_out.sleeping    = r_out.sleeping;

endmodule
